>>> rtl/core/jdd_pkg.sv
// shared types, codes and the quarter-wave sine table for the joystick drive mixer
package jdd_pkg;

   // drive command codes
   localparam logic [2:0] CMD_STOP   = 3'd0;
   localparam logic [2:0] CMD_FWD    = 3'd1;
   localparam logic [2:0] CMD_BWD    = 3'd2;
   localparam logic [2:0] CMD_ROT_L  = 3'd3;
   localparam logic [2:0] CMD_ROT_R  = 3'd4;
   localparam logic [2:0] CMD_NONE   = 3'd5;

   // motion state codes
   localparam logic [1:0] MS_STOPPED  = 2'd0;
   localparam logic [1:0] MS_FORWARD  = 2'd1;
   localparam logic [1:0] MS_BACKWARD = 2'd2;

   // csr register indexes
   localparam logic CSR_DEADZONE = 1'b0;
   localparam logic CSR_DEADBAND = 1'b1;

   // reset values of the csr registers
   localparam logic [6:0] DEADZONE_RESET = 7'd13;
   localparam logic [6:0] DEADBAND_RESET = 7'd10;

   localparam logic [6:0] SPEED_MAX = 7'd100;

   // floor(x / 100) == (x * DIV100_RECIP) >> DIV100_SHIFT for x below 43690
   localparam logic [14:0] DIV100_RECIP = 15'd5243;
   localparam int          DIV100_SHIFT = 19;

   typedef enum logic [1:0] {
      MUL_SIDE,
      MUL_FWD,
      MUL_CUT,
      MUL_DIV
   } mul_sel_type;

   typedef struct packed {
      logic        load;       // take the input transfer
      logic        prep;       // latch table indexes and signs
      logic        mul_en;     // run the shared multiplier
      mul_sel_type mul_sel;
      logic        emit_stop;  // load a stop result
      logic        emit_move;  // load a drive result
   } ctl_cmd_type;

   typedef struct packed {
      logic below_dz;  // magnitude at or under the deadzone
      logic stopped;   // motion state says stopped
      logic out_free;  // result register can take a new item
   } dp_status_type;

   // round(16384 * sin(d deg)) for d = 0..90
   localparam logic [14:0] SINE_Q14 [0:90] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
      15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
      15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
      15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
      15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
      15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
      15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
      15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
      15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
      15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
      15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
      15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
      15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
      15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
      15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
      15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
      15'd16384
   };

   function automatic logic [14:0] sine_lookup(input logic [6:0] idx);
      logic [14:0] val;
      val = 15'd0;
      if (idx <= 7'd90) begin
         val = SINE_Q14[idx];
      end
      return val;
   endfunction

endpackage

>>> rtl/core/jdd_ctrl.sv
// sequencer that steps one joystick event through the mixer datapath
module jdd_ctrl
   import jdd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SIDE,
      ST_FWD,
      ST_CUT,
      ST_DIV,
      ST_EMIT_MOVE,
      ST_EMIT_STOP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.mul_sel   = MUL_SIDE;
      in_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.prep = 1'b1;
            if (status.below_dz) begin
               state_in = status.stopped ? ST_IDLE : ST_EMIT_STOP;
            end else begin
               state_in = ST_SIDE;
            end
         end
         ST_SIDE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SIDE;
            state_in    = ST_FWD;
         end
         ST_FWD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_FWD;
            state_in    = ST_CUT;
         end
         ST_CUT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CUT;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DIV;
            state_in    = ST_EMIT_MOVE;
         end
         ST_EMIT_MOVE: begin
            if (status.out_free) begin
               cmd.emit_move = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT_STOP: begin
            if (status.out_free) begin
               cmd.emit_stop = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/jdd_datapath.sv
// mixer datapath: csr registers, sine lookup, shared multiplier, decision and result register
module jdd_datapath
   import jdd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   output dp_status_type status,
   input  logic [8:0]    angle_deg,
   input  logic [7:0]    magnitude_centi,
   input  logic          csr_write,
   input  logic          csr_index,
   input  logic [6:0]    csr_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_command,
   output logic [6:0]    rsp_left_speed,
   output logic [6:0]    rsp_right_speed
);

   logic [6:0]  deadzone_ff;
   logic [6:0]  deadband_ff;
   logic [1:0]  motion_ff;
   logic [1:0]  motion_in;

   logic [8:0]  angle_ff;
   logic [8:0]  angle_in;
   logic [7:0]  mag_ff;
   logic [6:0]  speed_ff;
   logic [6:0]  speed_in;

   logic [6:0]  side_idx_ff;
   logic [6:0]  fwd_idx_ff;
   logic        side_neg_ff;
   logic        fwd_neg_ff;
   logic        fwd_dir_ff;
   logic [6:0]  side_idx_in;
   logic [6:0]  fwd_idx_in;
   logic        side_neg_in;
   logic        fwd_neg_in;

   logic [7:0]  side_mag_ff;
   logic [7:0]  fwd_mag_ff;
   logic [14:0] cut_prod_ff;
   logic [7:0]  cut_ff;

   logic [14:0] mul_a;
   logic [14:0] mul_b;
   logic [29:0] mul_p;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_command_ff;
   logic [6:0]  rsp_left_ff;
   logic [6:0]  rsp_right_ff;

   logic        side_is_neg;
   logic        fwd_is_neg;
   logic        fwd_small;
   logic        side_small;
   logic [2:0]  dir_cmd;
   logic [6:0]  inner;
   logic [2:0]  move_cmd;
   logic [6:0]  move_left;
   logic [6:0]  move_right;

   // input stage: fold 360..511 back and clamp the speed
   always_comb begin
      angle_in = angle_deg;
      if (angle_deg >= 9'd360) begin
         angle_in = angle_deg - 9'd360;
      end
      speed_in = (magnitude_centi > {1'b0, SPEED_MAX}) ? SPEED_MAX : magnitude_centi[6:0];
   end

   // quadrant split into table indexes and component signs
   always_comb begin
      if (angle_ff <= 9'd90) begin
         side_idx_in = angle_ff[6:0];
         fwd_idx_in  = 7'(9'd90 - angle_ff);
         side_neg_in = 1'b0;
         fwd_neg_in  = 1'b0;
      end else if (angle_ff <= 9'd180) begin
         side_idx_in = 7'(9'd180 - angle_ff);
         fwd_idx_in  = 7'(angle_ff - 9'd90);
         side_neg_in = 1'b0;
         fwd_neg_in  = 1'b1;
      end else if (angle_ff <= 9'd270) begin
         side_idx_in = 7'(angle_ff - 9'd180);
         fwd_idx_in  = 7'(9'd270 - angle_ff);
         side_neg_in = 1'b1;
         fwd_neg_in  = 1'b1;
      end else begin
         side_idx_in = 7'(9'd360 - angle_ff);
         fwd_idx_in  = 7'(angle_ff - 9'd270);
         side_neg_in = 1'b1;
         fwd_neg_in  = 1'b0;
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_SIDE: begin
            mul_a = {7'd0, mag_ff};
            mul_b = sine_lookup(side_idx_ff);
         end
         MUL_FWD: begin
            mul_a = {7'd0, mag_ff};
            mul_b = sine_lookup(fwd_idx_ff);
         end
         MUL_CUT: begin
            mul_a = {8'd0, speed_ff};
            mul_b = {7'd0, side_mag_ff};
         end
         default: begin
            mul_a = cut_prod_ff;
            mul_b = DIV100_RECIP;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // move decision
   always_comb begin
      side_is_neg = side_neg_ff && (side_mag_ff != 8'd0);
      fwd_is_neg  = fwd_neg_ff && (fwd_mag_ff != 8'd0);
      fwd_small   = fwd_mag_ff <= {1'b0, deadband_ff};
      side_small  = side_mag_ff <= {1'b0, deadband_ff};
      dir_cmd     = fwd_is_neg ? CMD_BWD : CMD_FWD;
      inner       = (cut_ff >= {1'b0, speed_ff}) ? 7'd0 : 7'(speed_ff - cut_ff[6:0]);
      if (fwd_small) begin
         if (side_mag_ff == 8'd0) begin
            move_cmd   = CMD_NONE;
            move_left  = 7'd0;
            move_right = 7'd0;
         end else begin
            move_cmd   = side_is_neg ? CMD_ROT_L : CMD_ROT_R;
            move_left  = speed_ff;
            move_right = speed_ff;
         end
      end else if (side_small) begin
         move_cmd   = dir_cmd;
         move_left  = speed_ff;
         move_right = speed_ff;
      end else begin
         move_cmd   = dir_cmd;
         move_left  = side_is_neg ? inner : speed_ff;
         move_right = side_is_neg ? speed_ff : inner;
      end
   end

   always_comb begin
      motion_in = motion_ff;
      if (cmd.emit_stop) begin
         motion_in = MS_STOPPED;
      end else if (cmd.emit_move) begin
         motion_in = fwd_dir_ff ? MS_FORWARD : MS_BACKWARD;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff  <= DEADZONE_RESET;
         deadband_ff  <= DEADBAND_RESET;
         motion_ff    <= MS_STOPPED;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_DEADZONE) begin
               deadzone_ff <= csr_data;
            end else begin
               deadband_ff <= csr_data;
            end
         end
         motion_ff <= motion_in;
         if (cmd.emit_stop || cmd.emit_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         angle_ff <= angle_in;
         mag_ff   <= magnitude_centi;
         speed_ff <= speed_in;
      end
      if (cmd.prep) begin
         side_idx_ff <= side_idx_in;
         fwd_idx_ff  <= fwd_idx_in;
         side_neg_ff <= side_neg_in;
         fwd_neg_ff  <= fwd_neg_in;
         fwd_dir_ff  <= (angle_ff >= 9'd270) || (angle_ff <= 9'd90);
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_SIDE: side_mag_ff <= mul_p[21:14];
            MUL_FWD:  fwd_mag_ff  <= mul_p[21:14];
            MUL_CUT:  cut_prod_ff <= mul_p[14:0];
            default:  cut_ff      <= mul_p[DIV100_SHIFT +: 8];
         endcase
      end
      if (cmd.emit_stop) begin
         rsp_command_ff <= CMD_STOP;
         rsp_left_ff    <= 7'd0;
         rsp_right_ff   <= 7'd0;
      end else if (cmd.emit_move) begin
         rsp_command_ff <= move_cmd;
         rsp_left_ff    <= move_left;
         rsp_right_ff   <= move_right;
      end
   end

   assign status.below_dz = mag_ff <= {1'b0, deadzone_ff};
   assign status.stopped  = motion_ff == MS_STOPPED;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = rsp_command_ff;
   assign rsp_left_speed  = rsp_left_ff;
   assign rsp_right_speed = rsp_right_ff;

endmodule

>>> rtl/core/joystick_to_differential_drive.sv
// top level of the joystick to differential drive mixer
//
// req channel: one transfer per joystick event, angle in degrees (0 ahead) and
//   deflection in hundredths; angles 360..511 are folded back by 360
// rsp channel: at most one drive result per event: command plus left and
//   right wheel speed in percent
// csr channel: index 0 deadzone, index 1 axis deadband; always ready, write
//   only while no event is in flight
// an event above the deadzone walks check, two table multiplies, the inner
//   wheel product and a reciprocal multiply for the divide by 100 through one
//   shared multiplier, then the result is loaded once the output register is
//   free; req_tready comes back the cycle after the result is loaded, so a new
//   event is taken only when the last one is through
// an event at or under the deadzone skips the multiplies and gives a stop only
//   if the block was moving
// the result sits in an output register; a new event is taken while it waits,
//   and the sequencer holds its next result until rsp_tready frees the register
// reset restores deadzone 13, deadband 10 and the stopped state and drops
//   any pending result
module joystick_to_differential_drive
   import jdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // angle_deg [8:0], magnitude_centi [16:9], zero pad
   // rsp channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // command [2:0], left_speed [9:3], right_speed [16:10], zero
   // csr write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          in_ready;
   logic [2:0]    rsp_command;
   logic [6:0]    rsp_left_speed;
   logic [6:0]    rsp_right_speed;

   jdd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (in_ready),
      .status   (status),
      .cmd      (cmd)
   );

   jdd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .angle_deg       (req_tdata[8:0]),
      .magnitude_centi (req_tdata[16:9]),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_command     (rsp_command),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed)
   );

   assign req_tready = in_ready;
   // registers take a write every cycle
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = {7'd0, rsp_right_speed, rsp_left_speed, rsp_command};

endmodule

>>> verif/jdd_drive_checker.sv
`timescale 1ns / 1ps
// checker for the joystick drive mixer: predicts each drive result and compares it
module jdd_drive_checker
   import jdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // angle_deg [8:0], magnitude_centi [16:9], zero pad
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // command [2:0], left_speed [9:3], right_speed [16:10]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [2:0] cmd;
      logic [6:0] left;
      logic [6:0] right;
   } drive_type;

   // round(16384 * sin(d deg)), d = 0..90
   localparam int QUARTER_SINE [0:90] = '{
      0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
      2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
      5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
      8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384
   };

   localparam int MAX_REPORTS = 50;

   drive_type  pending_drives [$];
   logic [6:0] deadzone;
   logic [6:0] deadband;
   logic [1:0] motion;
   int         errors = 0;

   // truncated component, sign applied after the product
   function automatic int component(input int mag, input int idx, input bit neg);
      int p;
      p = (mag * QUARTER_SINE[idx]) >>> 14;
      return neg ? -p : p;
   endfunction

   function automatic int abs_of(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // one joystick event: returns 1 when it yields a drive result
   function automatic bit mix_joystick(input logic [8:0] angle_in, input logic [7:0] mag_in,
                                       input logic [6:0] dz, input logic [6:0] db,
                                       input logic [1:0] ms_in, output logic [1:0] ms_out,
                                       output drive_type res);
      int a, mag, speed, side, fwd, cut, inner;
      a = angle_in;
      mag = mag_in;
      speed = (mag > 100) ? 100 : mag;
      ms_out = ms_in;
      res = '0;
      if (a >= 360) a = a - 360;
      if (mag <= int'(dz)) begin
         if (ms_in == MS_STOPPED) return 1'b0;
         ms_out = MS_STOPPED;
         res.cmd = CMD_STOP;
         return 1'b1;
      end
      if (a <= 90) begin
         side = component(mag, a, 1'b0);
         fwd = component(mag, 90 - a, 1'b0);
      end else if (a <= 180) begin
         side = component(mag, 180 - a, 1'b0);
         fwd = component(mag, a - 90, 1'b1);
      end else if (a <= 270) begin
         side = component(mag, a - 180, 1'b1);
         fwd = component(mag, 270 - a, 1'b1);
      end else begin
         side = component(mag, 360 - a, 1'b1);
         fwd = component(mag, a - 270, 1'b0);
      end
      res.cmd = CMD_NONE;
      if (abs_of(fwd) <= int'(db)) begin
         if (side != 0) begin
            res.cmd = (side < 0) ? CMD_ROT_L : CMD_ROT_R;
            res.left = 7'(speed);
            res.right = 7'(speed);
         end
      end else if (abs_of(side) <= int'(db)) begin
         res.cmd = (fwd < 0) ? CMD_BWD : CMD_FWD;
         res.left = 7'(speed);
         res.right = 7'(speed);
      end else begin
         cut = (speed * abs_of(side)) / 100;
         inner = (cut >= speed) ? 0 : speed - cut;
         res.cmd = (fwd < 0) ? CMD_BWD : CMD_FWD;
         res.left = 7'((side < 0) ? inner : speed);
         res.right = 7'((side < 0) ? speed : inner);
      end
      ms_out = (a >= 270 || a <= 90) ? MS_FORWARD : MS_BACKWARD;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      drive_type  want;
      drive_type  got;
      logic [1:0] motion_next;
      if (reset) begin
         deadzone = DEADZONE_RESET;
         deadband = DEADBAND_RESET;
         motion = MS_STOPPED;
         pending_drives.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DEADZONE) deadzone = csr_data;
            else deadband = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.cmd = rsp_tdata[2:0];
            got.left = rsp_tdata[9:3];
            got.right = rsp_tdata[16:10];
            if (pending_drives.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: result with none expected, actual cmd %0d left %0d right %0d",
                           $time, got.cmd, got.left, got.right);
            end else begin
               want = pending_drives.pop_front();
               if (got.cmd !== want.cmd) report_mismatch("command", want.cmd, got.cmd);
               if (got.left !== want.left) report_mismatch("left_speed", want.left, got.left);
               if (got.right !== want.right)
                  report_mismatch("right_speed", want.right, got.right);
            end
         end
         if (req_tvalid && req_tready) begin
            if (mix_joystick(req_tdata[8:0], req_tdata[16:9], deadzone, deadband, motion,
                             motion_next, want))
               pending_drives.push_back(want);
            motion = motion_next;
         end
      end
      pending <= pending_drives.size();
      fail_count <= errors;
   end

endmodule

>>> verif/tb_joystick_to_differential_drive.sv
`timescale 1ns / 1ps
// testbench top for the joystick drive mixer: stimulus, receiver, watchdog and verdict
module tb_joystick_to_differential_drive;
   import jdd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on any channel
   localparam int SETTLE_CYCLES  = 12;    // covers an event in flight that yields nothing
   localparam int HOLD_CYCLES    = 300;   // long receiver stall
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 125;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // angle_deg [8:0], magnitude_centi [16:9], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // command [2:0], left_speed [9:3], right_speed [16:10], zero
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [6:0]  csr_data;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   bit no_idle = 1'b0;   // both sides run without gaps
   bit hold_rsp = 1'b0;  // ask the receiver for one long stall
   int cur_deadzone = DEADZONE_RESET;

   joystick_to_differential_drive dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predicts and compares on its own, hands back failures and outstanding results
   jdd_drive_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // no transfer anywhere for too long means the block is stuck
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_joystick_to_differential_drive failed");
         $finish;
      end
   end

   // receiver: random gap before each result, one long stall on request
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            // stall counted here while the sender keeps offering events
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            gap = no_idle ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         // wait for the result transfer
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // one joystick event, random gap first, then hold until the transfer
   task automatic send_event(input int angle, input int mag);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, 8'(mag), 9'(angle)};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait until every expected result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr write, only called while the block is idle
   task automatic write_csr(input logic idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 7'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_DEADZONE) cur_deadzone = value;
   endtask

   // angles around the axes hit the rotate and straight bands, the rest anywhere
   function automatic int pick_angle();
      int a;
      if ($urandom_range(0, 1) == 0) begin
         a = (90 * $urandom_range(0, 3) + $urandom_range(0, 16) - 8 + 360) % 360;
         if (a < 152 && $urandom_range(0, 3) == 0) a = a + 360;
      end else begin
         a = $urandom_range(0, 511);
      end
      return a;
   endfunction

   initial begin
      int dz_val;
      int db_val;
      int lim;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_DEADZONE;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset settings: deadzone 13, deadband 10
      send_event(0, 0);       // stopped and under the deadzone: nothing comes back
      send_event(0, 100);     // straight forward
      send_event(0, 13);      // at the deadzone while moving: stop
      send_event(90, 100);    // rotate right
      send_event(270, 100);   // rotate left
      send_event(180, 255);   // backward, speed clamped to 100
      send_event(45, 255);    // curve with the inner wheel saturating at zero
      send_event(135, 60);    // backward curve
      send_event(225, 80);
      send_event(315, 50);    // forward curve to the left
      send_event(400, 70);    // angle folded back by 360
      send_event(511, 255);   // largest angle code, all bits set
      send_event(359, 255);
      send_event(1, 14);
      send_event(0, 12);      // stop
      send_event(90, 12);     // already stopped: nothing
      send_event(360, 255);
      send_event(450, 200);
      send_event(5, 101);
      drain();

      // deadband wider than the deadzone: rotation with no side gives none chosen
      write_csr(CSR_DEADZONE, 0);
      write_csr(CSR_DEADBAND, 100);
      send_event(0, 50);
      send_event(180, 1);
      send_event(90, 100);
      drain();

      // register values above 100 used as they are
      write_csr(CSR_DEADZONE, 127);
      write_csr(CSR_DEADBAND, 127);
      send_event(0, 127);
      send_event(0, 128);
      send_event(0, 255);
      drain();

      // random phases over several settings, reset values and extremes first
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin dz_val = DEADZONE_RESET; db_val = DEADBAND_RESET; end
            1: begin dz_val = 0;   db_val = 0;   end
            2: begin dz_val = 127; db_val = 127; end
            3: begin dz_val = 100; db_val = 100; end
            4: begin dz_val = 0;   db_val = 127; end
            5: begin dz_val = 127; db_val = 0;   end
            default: begin
               dz_val = $urandom_range(0, 60);
               db_val = $urandom_range(0, 127);
            end
         endcase
         write_csr(CSR_DEADZONE, dz_val);
         write_csr(CSR_DEADBAND, db_val);
         no_idle = (phase == 3);
         // long receiver stall: the block fills up and stops taking events
         if (phase == 6) hold_rsp = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            lim = (cur_deadzone + 2 > 255) ? 255 : cur_deadzone + 2;
            if ($urandom_range(0, 4) == 0)
               send_event(pick_angle(), $urandom_range(0, lim));
            else
               send_event(pick_angle(), $urandom_range(0, 255));
         end
         // sender pauses until every expected result has come
         drain();
      end
      no_idle = 1'b0;

      if (fail_count == 0 && pending == 0) begin
         $display("tb_joystick_to_differential_drive passed");
      end else begin
         $display("tb_joystick_to_differential_drive failed");
      end
      $finish;
   end

endmodule
